### design/idmc_pkg.sv
// shared constants for the interval cut cost block
`default_nettype none
package idmc_pkg;
  localparam int unsigned MaxCutsDefault = 64;
  localparam int unsigned PosBits = 24;
  localparam int unsigned LenBits = 24;
  localparam int unsigned CostBits = 30;
  localparam int unsigned StatusBits = 2;
  localparam logic [CostBits-1:0] CostMax = {CostBits{1'b1}};
  localparam logic [StatusBits-1:0] StatOk = 2'd0;
  localparam logic [StatusBits-1:0] StatTooMany = 2'd1;
  localparam logic [StatusBits-1:0] StatRange = 2'd2;
endpackage
`default_nettype wire

### design/idmc_cost_ram.sv
// cost table memory, one write and one registered read port
`default_nettype none
module idmc_cost_ram
  import idmc_pkg::*;
#(
  parameter int unsigned Depth = 4356,
  parameter int unsigned AddrBits = 13
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [AddrBits-1:0] waddr_i,
  input  wire logic [CostBits-1:0] wdata_i,
  input  wire logic [AddrBits-1:0] raddr_i,
  output logic      [CostBits-1:0] rdata_o
);
  logic [CostBits-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

### design/interval_dp_min_cut_cost.sv
// top level of the interval cut cost block
// Cut positions arrive as input beats; each one is checked and inserted into a
// sorted list held in a small memory with registered reads: every larger entry
// moves up by a read, then a write. On the beat marked last (after its own
// insertion) the end points are added and a bottom-up interval program runs
// over one shared add/compare unit: each candidate split takes two table reads
// through the single read port of the cost memory, then an add and compare,
// and each interval also reads its end points and writes its cost. An error
// set skips the program and answers from the base state. The result beat
// waits in an output register; no new beat is taken until it has left. The
// cost table needs no clearing as each entry is written first.
`default_nettype none
module interval_dp_min_cut_cost
  import idmc_pkg::*;
#(
  parameter int unsigned MAX_CUTS = MaxCutsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // cut_position
  input  wire logic        s_axis_tlast_i,   // last_cut
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o    // min_cost[29:0], status[31:30]
);
  localparam int unsigned Npts = MAX_CUTS + 2;
  localparam int unsigned IdxBits = $clog2(Npts + 1);
  localparam int unsigned PBits = $clog2(Npts);
  localparam int unsigned ADepth = Npts * Npts;
  localparam int unsigned ABits = $clog2(ADepth);

  typedef enum logic [3:0] {
    S_IDLE, S_INS, S_SHF, S_BASE, S_INT, S_RA, S_RB, S_ACC, S_WR, S_OUT
  } state_e;

  state_e state_q;
  logic [LenBits-1:0] len_q;
  logic [PosBits-1:0] pos [Npts];   // sorted list, two registered read ports
  logic [PosBits-1:0] pos_a_q, pos_b_q;
  logic pos_we;
  logic [PBits-1:0] pos_wa, pos_ra_a, pos_ra_b;
  logic [PosBits-1:0] pos_wd;
  logic [PosBits-1:0] ins_q;
  logic [IdxBits-1:0] cnt_q, k_q, w_q, l_q, m_q, last_q;
  logic [1:0] err_q;
  logic lastf_q;
  logic [31:0] best_q;
  logic [CostBits-1:0] ca_q;
  logic [PosBits-1:0] span_q;
  logic [31:0] out_q;

  logic ram_we;
  logic [ABits-1:0] ram_wa, ram_ra;
  logic [CostBits-1:0] ram_wd, ram_rd;

  idmc_cost_ram #(.Depth(ADepth), .AddrBits(ABits)) u_ram (
    .clk_i, .we_i(ram_we), .waddr_i(ram_wa), .wdata_i(ram_wd),
    .raddr_i(ram_ra), .rdata_o(ram_rd)
  );

  function automatic logic [ABits-1:0] addr(input logic [IdxBits-1:0] a,
                                             input logic [IdxBits-1:0] b);
    logic [2*IdxBits+8:0] t;
    t = (2*IdxBits+9)'(a) * (2*IdxBits+9)'(Npts) + (2*IdxBits+9)'(b);
    return t[ABits-1:0];
  endfunction

  logic [PosBits-1:0] in_pos, len_p;
  assign in_pos = s_axis_tdata_i[PosBits-1:0];
  assign len_p = len_q[PosBits-1:0];
  logic [IdxBits-1:0] r;
  assign r = l_q + w_q;
  // shared unit: candidate sum and compare
  logic [31:0] cand;
  assign cand = 32'(span_q) + 32'(ca_q) + 32'(ram_rd);

  always_comb begin
    ram_we = 1'b0;
    ram_wa = addr(l_q, r);
    ram_wd = (best_q > 32'(CostMax)) ? CostMax : best_q[CostBits-1:0];
    ram_ra = addr(l_q, m_q);
    if (state_q == S_BASE) begin
      ram_we = 1'b1;
      ram_wa = addr(l_q, l_q + IdxBits'(1));
      ram_wd = '0;
    end else if (state_q == S_WR) ram_we = 1'b1;
    if (state_q == S_RA) ram_ra = addr(m_q, r);
    if (state_q == S_OUT) ram_ra = addr('0, last_q);
  end

  // sorted list port control: one write, reads of both interval ends
  always_comb begin
    pos_we = 1'b0;
    pos_wa = PBits'(k_q);
    pos_wd = ins_q;
    pos_ra_a = PBits'(r);
    pos_ra_b = PBits'(l_q);
    if (state_q == S_INS) begin
      pos_ra_a = PBits'(k_q - IdxBits'(1));
      pos_we = (k_q <= IdxBits'(1));
    end else if (state_q == S_SHF) begin
      pos_we = 1'b1;
      if (pos_a_q > ins_q) pos_wd = pos_a_q;
    end else if (state_q == S_BASE && err_q == 2'd0) begin
      // end points: zero first, then the stick length
      pos_we = 1'b1;
      if (l_q == '0) begin
        pos_wa = '0;
        pos_wd = '0;
      end else begin
        pos_wa = PBits'(cnt_q + IdxBits'(1));
        pos_wd = len_p;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos[pos_wa] <= pos_wd;
    pos_a_q <= pos[pos_ra_a];
    pos_b_q <= pos[pos_ra_b];
  end

  assign s_axis_tready_o = (state_q == S_IDLE) && !m_axis_tvalid_o;
  assign m_axis_tdata_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q <= LenBits'(2);
      cnt_q <= '0;
      err_q <= '0;
      m_axis_tvalid_o <= 1'b0;
    end else begin
      if (cfg_we_i) len_q <= cfg_wdata_i;
      if (m_axis_tvalid_o && m_axis_tready_i) m_axis_tvalid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i && s_axis_tready_o) begin
            lastf_q <= s_axis_tlast_i;
            state_q <= S_BASE;
            if (in_pos == '0 || in_pos >= len_p) begin
              if (err_q == 2'd0) err_q <= StatRange;
            end else if (cnt_q >= IdxBits'(MAX_CUTS)) begin
              if (err_q == 2'd0) err_q <= StatTooMany;
            end else begin
              ins_q <= in_pos;
              k_q <= cnt_q + IdxBits'(1);
              cnt_q <= cnt_q + IdxBits'(1);
              state_q <= S_INS;
            end
            l_q <= '0;
            if (!s_axis_tlast_i && !(in_pos != '0 && in_pos < len_p
                                     && cnt_q < IdxBits'(MAX_CUTS)))
              state_q <= S_IDLE;
          end
        end
        S_INS: begin
          // insertion: read the entry below, or place the cut at the bottom
          if (k_q > IdxBits'(1)) state_q <= S_SHF;
          else begin
            state_q <= lastf_q ? S_BASE : S_IDLE;
            l_q <= '0;
          end
        end
        S_SHF: begin
          // move one larger entry up, else the cut lands here
          if (pos_a_q > ins_q) begin
            k_q <= k_q - IdxBits'(1);
            state_q <= S_INS;
          end else begin
            state_q <= lastf_q ? S_BASE : S_IDLE;
            l_q <= '0;
          end
        end
        S_BASE: begin
          if (err_q != 2'd0) begin
            out_q <= {err_q, {CostBits{1'b0}}};
            m_axis_tvalid_o <= 1'b1;
            err_q <= '0;
            cnt_q <= '0;
            state_q <= S_IDLE;
          end else begin
            last_q <= cnt_q + IdxBits'(1);
            if (l_q == cnt_q) begin
              w_q <= IdxBits'(2);
              l_q <= '0;
              state_q <= (cnt_q == '0) ? S_OUT : S_INT;
            end else l_q <= l_q + IdxBits'(1);
          end
        end
        S_INT: begin
          // end points of the interval are read this cycle
          best_q <= '1;
          m_q <= l_q + IdxBits'(1);
          state_q <= S_RA;
        end
        S_RA: begin
          span_q <= pos_a_q - pos_b_q;
          state_q <= S_RB;          // read of (m,r) issued
        end
        S_RB: begin
          ca_q <= ram_rd;           // (l,m) read issued this cycle
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (cand < best_q) best_q <= cand;
          if (m_q + IdxBits'(1) == r) state_q <= S_WR;
          else begin
            m_q <= m_q + IdxBits'(1);
            state_q <= S_RA;
          end
        end
        S_WR: begin
          if (r == last_q) begin
            if (w_q == last_q) state_q <= S_OUT;
            else begin
              w_q <= w_q + IdxBits'(1);
              l_q <= '0;
              state_q <= S_INT;
            end
          end else begin
            l_q <= l_q + IdxBits'(1);
            state_q <= S_INT;
          end
          m_q <= '0;
        end
        S_OUT: begin
          if (m_q == '0) m_q <= IdxBits'(1);  // wait for registered read
          else begin
            out_q <= {StatOk, ram_rd};
            m_axis_tvalid_o <= 1'b1;
            cnt_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !s_axis_tready_o)
    else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= IdxBits'(MAX_CUTS))
    else $error("cut count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> (m_axis_tdata_o[31:30] != 2'd3))
    else $error("bad status");
endmodule
`default_nettype wire

### tb/sv/interval_dp_min_cut_cost_tb.sv
// self-checking testbench for the interval cut cost block
`timescale 1ns / 100ps
`default_nettype none
module interval_dp_min_cut_cost_tb;
  import idmc_pkg::*;

  localparam int unsigned NumCuts = MaxCutsDefault;
  localparam int unsigned NumPts = NumCuts + 2;

  // one closed set gives one of these
  typedef struct packed {
    logic [CostBits-1:0]   cost;
    logic [StatusBits-1:0] status;
  } cut_result_t;

  // directed row: optional length write, then one cut beat
  typedef struct {
    int                    new_len;   // -1 keeps the current length
    logic [LenBits-1:0]    pos;
    bit                    last;
    bit                    typed;     // result typed in below
    logic [CostBits-1:0]   cost;
    logic [StatusBits-1:0] status;
  } cut_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [23:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i = '0;   // cut_position
  logic        s_axis_tlast_i = 1'b0; // last_cut
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;        // min_cost[29:0], status[31:30]

  interval_dp_min_cut_cost dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #6 clk_i = ~clk_i;

  // predictor state, kept apart from the block
  logic [LenBits-1:0]    stick_len = 24'd2;
  logic [LenBits-1:0]    cut_list [NumPts];
  longint unsigned       span_cost [NumPts][NumPts];
  int unsigned           cuts_held = 0;
  logic [StatusBits-1:0] set_error = StatOk;

  cut_result_t pending_results [$];
  int          mismatches = 0;
  int          beats_sent = 0;
  int          tx_idle_pct = 31;
  int          rx_idle_pct = 72;

  // bottom-up pass over widening intervals between the sorted points
  function automatic logic [CostBits-1:0] cheapest_cut_cost();
    int unsigned top, w, l, r, m;
    longint unsigned best, cand;
    top = cuts_held + 1;
    cut_list[0] = '0;
    cut_list[top] = stick_len;
    for (l = 0; l < top; l++) span_cost[l][l+1] = 0;
    for (w = 2; w <= top; w++) begin
      for (l = 0; l + w <= top; l++) begin
        r = l + w;
        best = 64'hFFFF_FFFF_FFFF_FFFF;
        for (m = l + 1; m < r; m++) begin
          cand = longint'(cut_list[r]) - longint'(cut_list[l])
                 + span_cost[l][m] + span_cost[m][r];
          if (cand < best) best = cand;
        end
        if (best > longint'(CostMax)) best = longint'(CostMax);
        span_cost[l][r] = best;
      end
    end
    return span_cost[0][top][CostBits-1:0];
  endfunction

  // take one accepted cut beat into the predictor; queue a result on last
  function automatic void absorb_cut(logic [LenBits-1:0] pos, bit last);
    int unsigned k;
    cut_result_t res;
    if (pos == 0 || pos >= stick_len) begin
      if (set_error == StatOk) set_error = StatRange;
    end else if (cuts_held >= NumCuts) begin
      if (set_error == StatOk) set_error = StatTooMany;
    end else begin
      // insertion keeps entries 1..cuts_held ascending
      k = cuts_held + 1;
      while (k > 1 && cut_list[k-1] > pos) begin
        cut_list[k] = cut_list[k-1];
        k--;
      end
      cut_list[k] = pos;
      cuts_held++;
    end
    if (!last) return;
    if (set_error != StatOk) begin
      res.cost = '0;
      res.status = set_error;
    end else begin
      res.cost = cheapest_cut_cost();
      res.status = StatOk;
    end
    pending_results = {pending_results, res};
    cuts_held = 0;
    set_error = StatOk;
  endfunction

  // receiver side: random stalls on tready
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= rx_idle_pct);
  end

  // result checker, sampled on the edge that moves the beat
  always @(posedge clk_i) begin
    cut_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat, got cost %0d status %0d", $time,
                 m_axis_tdata_o[29:0], m_axis_tdata_o[31:30]);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata_o[29:0] !== want.cost) begin
          $display("%0t: min_cost expected %0d got %0d", $time, want.cost,
                   m_axis_tdata_o[29:0]);
          mismatches++;
        end
        if (m_axis_tdata_o[31:30] !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status,
                   m_axis_tdata_o[31:30]);
          mismatches++;
        end
      end
    end
  end

  // send one cut beat; tvalid stays high only until the next call decides
  task automatic send_cut(logic [LenBits-1:0] pos, bit last);
    int gap;
    if (beats_sent < 280) begin
      tx_idle_pct = 31; rx_idle_pct = 72;
    end else if (beats_sent < 560) begin
      tx_idle_pct = 72; rx_idle_pct = 31;
    end else begin
      tx_idle_pct = 0; rx_idle_pct = 0;
    end
    if ($urandom_range(99) < tx_idle_pct) begin
      gap = $urandom_range(4, 1);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= pos;
    s_axis_tlast_i <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    absorb_cut(pos, last);
    beats_sent++;
  endtask

  // drain all results, then let the block settle before a register write
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_stick_len(logic [LenBits-1:0] len);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    stick_len = len;
  endtask

  cut_row_t cut_table [] = '{
    // reset length 2: only position 1 is legal, one cut costs 2
    '{-1, 24'd1, 1, 1, 30'd2, StatOk},
    '{-1, 24'd0, 1, 1, 30'd0, StatRange},
    '{-1, 24'd2, 1, 1, 30'd0, StatRange},
    '{-1, 24'hFFFFFF, 1, 1, 30'd0, StatRange},
    // short stick, unsorted cuts
    '{10, 24'd5, 0, 0, 30'd0, StatOk},
    '{-1, 24'd2, 0, 0, 30'd0, StatOk},
    '{-1, 24'd8, 1, 0, 30'd0, StatOk},
    // duplicates add free zero-length pieces
    '{-1, 24'd5, 0, 0, 30'd0, StatOk},
    '{-1, 24'd5, 1, 1, 30'd15, StatOk},
    // range error held, later legal cut ignored
    '{-1, 24'd0, 0, 0, 30'd0, StatOk},
    '{-1, 24'd3, 1, 1, 30'd0, StatRange},
    '{-1, 24'd10, 0, 0, 30'd0, StatOk},
    '{-1, 24'd9, 1, 1, 30'd0, StatRange},
    // longest stick, cuts at both ends
    '{24'hFFFFFF, 24'hFFFFFE, 0, 0, 30'd0, StatOk},
    '{-1, 24'd1, 1, 0, 30'd0, StatOk},
    '{-1, 24'h800000, 1, 1, 30'h00FFFFFF, StatOk},
    '{-1, 24'h7FFFFF, 0, 0, 30'd0, StatOk},
    '{-1, 24'h555555, 0, 0, 30'd0, StatOk},
    '{-1, 24'hAAAAAA, 1, 0, 30'd0, StatOk}
  };

  initial begin
    cut_result_t typed_res;
    int len, n, r;
    logic [LenBits-1:0] pos;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (cut_table[i]) begin
      if (cut_table[i].new_len >= 0) write_stick_len(LenBits'(cut_table[i].new_len));
      send_cut(cut_table[i].pos, cut_table[i].last);
      if (cut_table[i].typed) begin
        // swap the predicted entry for the one typed in
        typed_res.cost = cut_table[i].cost;
        typed_res.status = cut_table[i].status;
        pending_results[pending_results.size() - 1] = typed_res;
      end
    end

    // full set of cuts: the largest program the block runs
    write_stick_len(24'd1000);
    for (int i = 0; i < NumCuts; i++)
      send_cut(LenBits'($urandom_range(999, 1)), i == NumCuts - 1);
    // one cut too many, then a range error that must not replace it
    for (int i = 0; i < NumCuts; i++) send_cut(LenBits'($urandom_range(999, 1)), 1'b0);
    send_cut(24'd500, 1'b0);
    send_cut(24'd0, 1'b1);
    // too many cuts closing on the surplus beat itself
    for (int i = 0; i <= NumCuts; i++) send_cut(LenBits'(i + 1), i == NumCuts);

    // random sets, small most of the time
    while (beats_sent < 850) begin
      if ($urandom_range(9) == 0) begin
        r = $urandom_range(5);
        case (r)
          0: len = 2;
          1: len = 24'hFFFFFF;
          2: len = $urandom_range(300, 2);
          default: len = ($urandom & 24'hFFFFFF) | 24'd2;
        endcase
        write_stick_len(LenBits'(len));
      end
      n = ($urandom_range(19) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(19) == 0)
          pos = ($urandom_range(1) == 0) ? '0 : (LenBits'($urandom) | stick_len);
        else
          pos = LenBits'($urandom_range(stick_len - 1, 1));
        send_cut(pos, i == n - 1);
      end
    end

    drain_results();
    repeat (200) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // watchdog
  initial begin
    #80_000_000;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
design/idmc_pkg.sv
design/idmc_cost_ram.sv
design/interval_dp_min_cut_cost.sv
tb/sv/interval_dp_min_cut_cost_tb.sv
